// ===== rtl/rgbled_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED sequencer package
// Shared constants, codes, queue entry layout and controller/datapath links
// for the RGB LED command sequencer.
// ----------------------------------------------------------------------------
package rgbled_pkg;

    // Queue geometry and duration counter width.
    localparam int QUEUE_DEPTH   = 16;
    localparam int DURATION_BITS = 16;
    localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] COLOR_OFF = 3'd0;

    // Command codes carried on the action field.
    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_ON          = 3'd1,
        ACT_OFF         = 3'd2,
        ACT_ON_DURATION = 3'd3,
        ACT_BLINK_START = 3'd4,
        ACT_BLINK_STOP  = 3'd5,
        ACT_HOLD_ON     = 3'd6,
        ACT_HOLD_OFF    = 3'd7
    } action_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BLINKING     = 3'd1,
        ST_BUSY         = 3'd2,
        ST_FULL         = 3'd3,
        ST_NOT_BLINKING = 3'd4
    } status_t;

    // One queued entry.
    typedef struct packed {
        logic [2:0]               color;
        logic [DURATION_BITS-1:0] duration;
        logic                     blink;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic push2;
        logic rd;
        logic load;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic second_push;
        logic pop_ready;
        logic out_free;
    } dp_status_t;

    // Advance a queue pointer with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rgbled_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED sequencer controller
// Steps one command beat through execute, optional second push, queue pop
// and result hand-off.
// ----------------------------------------------------------------------------
module rgbled_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  rgbled_pkg::dp_status_t   st,
    output rgbled_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH2,
        S_CHECK,
        S_LOAD,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = st.second_push ? S_PUSH2 : S_CHECK;
            end
            S_PUSH2: begin
                cmd.push2  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (st.pop_ready) begin
                    cmd.rd     = 1'b1;
                    state_next = S_LOAD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/rgbled_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED sequencer datapath
// Command queue memory, pointers, entry countdown, LED drive and the
// result register.
// ----------------------------------------------------------------------------
module rgbled_datapath (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_wr_en,
    input  wire  [2:0]               cfg_wr_data,
    input  wire  [2:0]               s_action,
    input  wire  [2:0]               s_color,
    input  wire  [15:0]              s_duration_ms,
    output logic                     m_valid,
    input  wire                      m_ready,
    output logic [2:0]               m_led_color,
    output logic [2:0]               m_status,
    output logic                     m_busy_res,
    output logic [4:0]               m_queue_count,
    input  rgbled_pkg::ctrl_cmd_t    cmd,
    output rgbled_pkg::dp_status_t   st
);

    localparam int PW = rgbled_pkg::PTR_W;
    localparam int CW = rgbled_pkg::COUNT_W;
    localparam int DW = rgbled_pkg::DURATION_BITS;

    // Captured command beat.
    rgbled_pkg::action_t action_reg;
    logic [2:0]          color_reg;
    logic [DW-1:0]       dur_reg;

    // Queue storage and control.
    rgbled_pkg::entry_t  queue_mem [rgbled_pkg::QUEUE_DEPTH];
    rgbled_pkg::entry_t  rd_data_reg;
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       pending_reg, pending_next;

    // Sequencer state.
    logic                in_process_reg, in_process_next;
    logic                blinking_reg, blinking_next;
    logic                hold_active_reg, hold_active_next;
    logic                blink_phase_reg, blink_phase_next;
    logic [DW-1:0]       ticks_left_reg, ticks_left_next;
    logic [2:0]          entry_color_reg, entry_color_next;
    logic [DW-1:0]       entry_period_reg, entry_period_next;
    logic [2:0]          drive_color_reg, drive_color_next;
    logic [2:0]          hold_color_reg;
    rgbled_pkg::status_t status_reg, status_next;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic [2:0]          m_led_color_reg;
    logic [2:0]          m_status_reg;
    logic                m_busy_res_reg;
    logic [4:0]          m_queue_count_reg;

    // Command evaluation results.
    logic                push_req;
    logic                push_ok;
    logic                dual_push;
    logic                blink_eff;
    logic                queue_full;
    rgbled_pkg::entry_t  push_data;
    rgbled_pkg::entry_t  off_entry;
    rgbled_pkg::status_t status_calc;
    logic                hold_calc;
    logic                blink_calc;
    logic [DW-1:0]       ticks_dec;
    logic                mem_we;
    rgbled_pkg::entry_t  mem_wdata;
    logic                new_phase;

    assign off_entry  = '{color: rgbled_pkg::COLOR_OFF, duration: '0, blink: 1'b0};
    assign queue_full = (pending_reg == CW'(rgbled_pkg::QUEUE_DEPTH));
    // A blink stop clears blinking before its own off entry is pushed.
    assign blink_eff  = blinking_reg && (action_reg != rgbled_pkg::ACT_BLINK_STOP);

    // Decode the captured command into a push request and a status.
    always_comb begin
        push_req    = 1'b0;
        dual_push   = 1'b0;
        push_data   = off_entry;
        status_calc = rgbled_pkg::ST_OK;
        hold_calc   = hold_active_reg;
        blink_calc  = blinking_reg;
        unique case (action_reg)
            rgbled_pkg::ACT_TICK: begin
                push_req = 1'b0;
            end
            rgbled_pkg::ACT_ON: begin
                push_req  = 1'b1;
                push_data = '{color: color_reg, duration: '0, blink: 1'b0};
            end
            rgbled_pkg::ACT_OFF: begin
                push_req = 1'b1;
            end
            rgbled_pkg::ACT_ON_DURATION: begin
                if (blinking_reg) begin
                    status_calc = rgbled_pkg::ST_BLINKING;
                end else if (pending_reg > CW'(rgbled_pkg::QUEUE_DEPTH - 2)) begin
                    status_calc = rgbled_pkg::ST_FULL;
                end else begin
                    push_req  = 1'b1;
                    dual_push = 1'b1;
                    push_data = '{color: color_reg, duration: dur_reg, blink: 1'b0};
                end
            end
            rgbled_pkg::ACT_BLINK_START: begin
                push_req  = 1'b1;
                push_data = '{color: color_reg, duration: dur_reg, blink: 1'b1};
            end
            rgbled_pkg::ACT_BLINK_STOP: begin
                if (!blinking_reg) begin
                    status_calc = rgbled_pkg::ST_NOT_BLINKING;
                end else begin
                    blink_calc = 1'b0;
                    push_req   = 1'b1;
                end
            end
            rgbled_pkg::ACT_HOLD_ON: begin
                if (in_process_reg || (pending_reg != '0)) begin
                    status_calc = rgbled_pkg::ST_BUSY;
                end else begin
                    hold_calc = 1'b1;
                    push_req  = 1'b1;
                    push_data = '{color: hold_color_reg, duration: '0, blink: 1'b0};
                end
            end
            rgbled_pkg::ACT_HOLD_OFF: begin
                hold_calc = 1'b0;
                push_req  = 1'b1;
            end
            default: begin
                push_req = 1'b0;
            end
        endcase

        // A push is refused while blinking or when the queue is full.
        push_ok = 1'b0;
        if (push_req) begin
            if (blink_eff) begin
                status_calc = rgbled_pkg::ST_BLINKING;
            end else if (queue_full) begin
                status_calc = rgbled_pkg::ST_FULL;
            end else begin
                status_calc = rgbled_pkg::ST_OK;
                push_ok     = 1'b1;
            end
        end
    end

    assign ticks_dec = (ticks_left_reg != '0) ? (ticks_left_reg - DW'(1)) : ticks_left_reg;
    assign new_phase = !blink_phase_reg;

    // Next values of the sequencer state.
    always_comb begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        pending_next      = pending_reg;
        in_process_next   = in_process_reg;
        blinking_next     = blinking_reg;
        hold_active_next  = hold_active_reg;
        blink_phase_next  = blink_phase_reg;
        ticks_left_next   = ticks_left_reg;
        entry_color_next  = entry_color_reg;
        entry_period_next = entry_period_reg;
        drive_color_next  = drive_color_reg;
        status_next       = status_reg;
        m_valid_next      = m_valid_reg;

        if (cmd.exec) begin
            status_next      = status_calc;
            hold_active_next = hold_calc;
            blinking_next    = blink_calc;
            if (push_ok) begin
                tail_next    = rgbled_pkg::next_slot(tail_reg);
                pending_next = pending_reg + CW'(1);
            end
            // Tick: count the active entry down and act when it expires.
            if ((action_reg == rgbled_pkg::ACT_TICK) && in_process_reg) begin
                if (ticks_dec != '0) begin
                    ticks_left_next = ticks_dec;
                end else if (blinking_reg) begin
                    blink_phase_next = new_phase;
                    drive_color_next = new_phase ? rgbled_pkg::COLOR_OFF : entry_color_reg;
                    ticks_left_next  = entry_period_reg;
                end else begin
                    ticks_left_next = ticks_dec;
                    in_process_next = 1'b0;
                    if (hold_active_reg && (entry_color_reg == rgbled_pkg::COLOR_OFF)) begin
                        drive_color_next = hold_color_reg;
                    end
                end
            end
        end

        // Off entry that follows an on-for-duration entry.
        if (cmd.push2) begin
            tail_next    = rgbled_pkg::next_slot(tail_reg);
            pending_next = pending_reg + CW'(1);
        end

        // Start the entry read from the head of the queue.
        if (cmd.load) begin
            head_next         = rgbled_pkg::next_slot(head_reg);
            pending_next      = pending_reg - CW'(1);
            in_process_next   = 1'b1;
            blinking_next     = rd_data_reg.blink;
            entry_color_next  = rd_data_reg.color;
            entry_period_next = (rd_data_reg.duration == '0) ? DW'(1) : rd_data_reg.duration;
            ticks_left_next   = (rd_data_reg.duration == '0) ? DW'(1) : rd_data_reg.duration;
            blink_phase_next  = 1'b0;
            drive_color_next  = rd_data_reg.color;
        end

        // Result register handshake.
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg         <= '0;
            tail_reg         <= '0;
            pending_reg      <= '0;
            in_process_reg   <= 1'b0;
            blinking_reg     <= 1'b0;
            hold_active_reg  <= 1'b0;
            blink_phase_reg  <= 1'b0;
            ticks_left_reg   <= '0;
            entry_color_reg  <= '0;
            entry_period_reg <= '0;
            drive_color_reg  <= rgbled_pkg::COLOR_OFF;
            hold_color_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            pending_reg      <= pending_next;
            in_process_reg   <= in_process_next;
            blinking_reg     <= blinking_next;
            hold_active_reg  <= hold_active_next;
            blink_phase_reg  <= blink_phase_next;
            ticks_left_reg   <= ticks_left_next;
            entry_color_reg  <= entry_color_next;
            entry_period_reg <= entry_period_next;
            drive_color_reg  <= drive_color_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_wr_en) begin
                hold_color_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: captured beat, step status and result fields.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= rgbled_pkg::action_t'(s_action);
            color_reg  <= s_color;
            dur_reg    <= DW'(s_duration_ms);
        end
        status_reg <= status_next;
        if (cmd.out_load) begin
            m_led_color_reg   <= drive_color_reg;
            m_status_reg      <= status_reg;
            m_busy_res_reg    <= in_process_reg;
            m_queue_count_reg <= 5'(pending_reg);
        end
    end

    // Queue memory: one write port at the tail, registered read at the head.
    assign mem_we    = (cmd.exec && push_ok) || cmd.push2;
    assign mem_wdata = cmd.push2 ? off_entry : push_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            queue_mem[tail_reg] <= mem_wdata;
        end
        if (cmd.rd) begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

    // Status to the controller.
    assign st.second_push = dual_push && push_ok;
    assign st.pop_ready   = !in_process_reg && (pending_reg != '0);
    assign st.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_led_color   = m_led_color_reg;
    assign m_status      = m_status_reg;
    assign m_busy_res    = m_busy_res_reg;
    assign m_queue_count = m_queue_count_reg;

endmodule
`default_nettype wire

// ===== rtl/rgb_led_command_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED command sequencer
// Queues LED commands, counts entries down on millisecond ticks and reports
// the LED color, a status, the busy flag and the queue fill per beat.
// ----------------------------------------------------------------------------
// Each accepted input beat (a command or a tick) yields exactly one result
// beat. The sequencer handles one beat at a time: after acceptance a beat
// steps through execute, a second push when an on-for-duration command
// pushes its off entry, a check and, when an idle sequencer has queued
// entries, a pop from the queue, and then its result is loaded into the
// output register; s_ready returns once the result is loaded. The step
// sequence is set by the controller around the queue memory with its
// registered read. A pending result may wait in the output register while
// the next beat is accepted and executed; that next beat then holds in its
// last step until the waiting result is accepted. The hold color register
// is written through cfg_wr_en/cfg_wr_data and should be changed only while
// the sequencer is idle.
module rgb_led_command_sequencer (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_action,
    input  wire  [2:0]  s_color,
    input  wire  [15:0] s_duration_ms,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [2:0]  m_led_color,
    output logic [2:0]  m_status,
    output logic        m_busy_res,
    output logic [4:0]  m_queue_count
);

    rgbled_pkg::ctrl_cmd_t  cmd;
    rgbled_pkg::dp_status_t st;

    // Step sequencer.
    rgbled_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Queue, countdown and result register.
    rgbled_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_action      (s_action),
        .s_color       (s_color),
        .s_duration_ms (s_duration_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_led_color   (m_led_color),
        .m_status      (m_status),
        .m_busy_res    (m_busy_res),
        .m_queue_count (m_queue_count),
        .cmd           (cmd),
        .st            (st)
    );

endmodule
`default_nettype wire

// ===== rtl/rgbled_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED sequencer checker
// Port-level assertions for the RGB LED command sequencer, bound to the
// top level.
// ----------------------------------------------------------------------------
module rgbled_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        cfg_wr_en,
    input wire [2:0]  cfg_wr_data,
    input wire        s_valid,
    input wire        s_ready,
    input wire [2:0]  s_action,
    input wire [2:0]  s_color,
    input wire [15:0] s_duration_ms,
    input wire        m_valid,
    input wire        m_ready,
    input wire [2:0]  m_led_color,
    input wire [2:0]  m_status,
    input wire        m_busy_res,
    input wire [4:0]  m_queue_count
);

    // A stalled result beat holds its fields.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_color) && $stable(m_status)
            && $stable(m_busy_res) && $stable(m_queue_count))
        else $error("result beat changed while stalled");

    // The sequencer takes one beat at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    // Only defined status codes are reported, and the fill never exceeds the depth.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 3'd5) && (m_status != 3'd6) && (m_status != 3'd7)
            && ((rgbled_pkg::QUEUE_DEPTH > 31)
                || (m_queue_count <= 5'(rgbled_pkg::QUEUE_DEPTH))))
        else $error("status or queue count out of range");

    // A busy or blinking rejection means an entry is being shown.
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == 3'(rgbled_pkg::ST_BUSY))
            || (m_status == 3'(rgbled_pkg::ST_BLINKING))) |-> m_busy_res)
        else $error("busy rejection reported while idle");

endmodule

bind rgb_led_command_sequencer rgbled_checker u_rgbled_checker (.*);
`default_nettype wire
